// ----- sv/jes_pkg.sv -----
package jes_pkg;

   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam int unsigned POS_W       = 32;
   localparam int unsigned MIN_SIZE_W  = 11;

   // register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_BUFFER_LENGTH = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_SIZE      = 1'd1;

   localparam logic [POS_W-1:0]      BUFFER_LENGTH_RESET = 32'd0;
   localparam logic [MIN_SIZE_W-1:0] MIN_SIZE_RESET      = 11'd4;

   // marker codes
   localparam logic [7:0] MRK_PREFIX = 8'hFF;
   localparam logic [7:0] MRK_STUFF  = 8'h00;
   localparam logic [7:0] MRK_TEM    = 8'h01;
   localparam logic [7:0] MRK_RST0   = 8'hD0;
   localparam logic [7:0] MRK_RST7   = 8'hD7;
   localparam logic [7:0] MRK_SOI    = 8'hD8;
   localparam logic [7:0] MRK_EOI    = 8'hD9;
   localparam logic [7:0] MRK_SOS    = 8'hDA;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_SOI1,
      PH_MARK0,
      PH_MARK1,
      PH_LENH,
      PH_LENL,
      PH_LENH_SOS,
      PH_LENL_SOS,
      PH_SKIP,
      PH_SKIP_SOS,
      PH_SCAN,
      PH_DONE
   } phase_type;

   typedef struct packed {
      phase_type        phase;
      logic [POS_W-1:0] pos;
      logic [POS_W:0]   seg_end;
      logic [7:0]       len_high;
      logic             pending_ff;
      logic             scan_seen;
      logic             body_seen;
   } state_type;

   typedef struct packed {
      logic             valid;
      logic             ok;
      logic [POS_W-1:0] len;
   } result_type;

endpackage

// ----- sv/jes_step.sv -----
module jes_step
   import jes_pkg::*;
(
   input  state_type              cur,
   input  logic [7:0]             data_byte,
   input  logic                   first_byte,
   input  logic [POS_W-1:0]       buffer_length,
   input  logic [MIN_SIZE_W-1:0]  min_size,
   output state_type              nxt,
   output result_type             res
);

   typedef struct packed {
      phase_type phase;
      logic      pending_ff;
      logic      fin;
      logic      ok;
   } outcome_type;

   localparam outcome_type O_REJECT = '{phase: PH_DONE, pending_ff: 1'b0, fin: 1'b1, ok: 1'b0};

   function automatic outcome_type go_outer(input logic [33:0] at, input logic [33:0] bl);
      outcome_type o;
      o = '{phase: PH_MARK0, pending_ff: 1'b0, fin: 1'b0, ok: 1'b0};
      if (at + 34'd2 > bl) begin
         o = O_REJECT;
      end
      return o;
   endfunction

   function automatic outcome_type go_scan(input logic [33:0] at, input logic [33:0] bl);
      outcome_type o;
      if (at + 34'd2 < bl) begin
         o = '{phase: PH_SCAN, pending_ff: 1'b0, fin: 1'b0, ok: 1'b0};
      end else begin
         o = go_outer(at, bl);
      end
      return o;
   endfunction

   function automatic outcome_type go_target(input logic sos, input logic [33:0] at,
                                             input logic [33:0] bl);
      outcome_type o;
      if (sos) begin
         o = go_scan(at, bl);
      end else begin
         o = go_outer(at, bl);
      end
      return o;
   endfunction

   function automatic outcome_type scan_first(input logic [7:0] b, input logic [33:0] p,
                                              input logic [33:0] bl);
      outcome_type o;
      if (b == MRK_PREFIX) begin
         o = '{phase: PH_SCAN, pending_ff: 1'b1, fin: 1'b0, ok: 1'b0};
      end else begin
         o = go_scan(p + 34'd1, bl);
      end
      return o;
   endfunction

   // second byte of a pair that started one byte earlier
   function automatic outcome_type mark_second(input logic [7:0] c, input logic [33:0] p,
                                               input logic ff, input logic body,
                                               input logic scan, input logic [33:0] bl);
      outcome_type o;
      logic        standalone;
      standalone = (c == MRK_TEM) || (c >= MRK_RST0 && c <= MRK_SOI);
      if (ff && c == MRK_EOI) begin
         o = '{phase: PH_DONE, pending_ff: 1'b0, fin: 1'b1, ok: body};
      end else if (ff && standalone) begin
         o = go_outer(p + 34'd1, bl);
      end else if (p + 34'd3 > bl) begin
         // truncated stream
         o = '{phase: PH_DONE, pending_ff: 1'b0, fin: 1'b1, ok: scan};
      end else if (ff && c != MRK_STUFF && c != MRK_PREFIX) begin
         o = '{phase: (c == MRK_SOS) ? PH_LENH_SOS : PH_LENH,
               pending_ff: 1'b0, fin: 1'b0, ok: 1'b0};
      end else begin
         o = O_REJECT;
      end
      return o;
   endfunction

   logic [33:0]  pos34;
   logic [33:0]  bl34;
   logic [15:0]  seg;
   logic [33:0]  seg_stop;
   logic         sos;
   logic         apply;
   outcome_type  o;

   assign pos34    = {2'b00, cur.pos};
   assign bl34     = {2'b00, buffer_length};
   assign seg      = {cur.len_high, data_byte};
   assign seg_stop = pos34 + {18'd0, seg} - 34'd1;
   assign sos      = (cur.phase == PH_LENL_SOS) || (cur.phase == PH_SKIP_SOS);

   always_comb begin
      nxt   = cur;
      apply = 1'b0;
      o     = O_REJECT;
      if (first_byte) begin
         nxt.pos        = 32'd1;
         nxt.seg_end    = '0;
         nxt.len_high   = '0;
         nxt.pending_ff = 1'b0;
         nxt.scan_seen  = 1'b0;
         nxt.body_seen  = 1'b0;
         apply          = 1'b1;
         if (buffer_length < {21'd0, min_size} || buffer_length < 32'd2 ||
             data_byte != MRK_PREFIX) begin
            o = O_REJECT;
         end else begin
            o = '{phase: PH_SOI1, pending_ff: 1'b0, fin: 1'b0, ok: 1'b0};
         end
      end else if (cur.phase != PH_IDLE && cur.phase != PH_DONE) begin
         nxt.pos = cur.pos + 32'd1;
         unique case (cur.phase)
            PH_SOI1: begin
               apply = 1'b1;
               o = (data_byte != MRK_SOI) ? O_REJECT : go_outer(34'd2, bl34);
            end
            PH_MARK0: begin
               nxt.pending_ff = (data_byte == MRK_PREFIX);
               nxt.phase      = PH_MARK1;
            end
            PH_MARK1: begin
               apply = 1'b1;
               o = mark_second(data_byte, pos34, cur.pending_ff, cur.body_seen,
                               cur.scan_seen, bl34);
            end
            PH_LENH, PH_LENH_SOS: begin
               nxt.len_high = data_byte;
               nxt.phase    = (cur.phase == PH_LENH) ? PH_LENL : PH_LENL_SOS;
            end
            PH_LENL, PH_LENL_SOS: begin
               if (seg < 16'd2) begin
                  apply = 1'b1;
                  o     = O_REJECT;
               end else begin
                  nxt.body_seen = 1'b1;
                  if (sos) begin
                     nxt.scan_seen = 1'b1;
                  end
                  if (seg_stop + 34'd2 > bl34) begin
                     apply = 1'b1;
                     o     = O_REJECT;
                  end else if (seg_stop == pos34 + 34'd1) begin
                     apply = 1'b1;
                     o     = go_target(sos, seg_stop, bl34);
                  end else begin
                     nxt.seg_end = seg_stop[32:0];
                     nxt.phase   = sos ? PH_SKIP_SOS : PH_SKIP;
                  end
               end
            end
            PH_SKIP, PH_SKIP_SOS: begin
               if (pos34 + 34'd1 >= {1'b0, cur.seg_end}) begin
                  apply = 1'b1;
                  o     = go_target(sos, {1'b0, cur.seg_end}, bl34);
               end
            end
            PH_SCAN: begin
               apply = 1'b1;
               if (!cur.pending_ff) begin
                  o = scan_first(data_byte, pos34, bl34);
               end else if (data_byte >= MRK_RST0 && data_byte <= MRK_RST7) begin
                  o = go_scan(pos34 + 34'd1, bl34);
               end else if (data_byte != MRK_STUFF && data_byte != MRK_PREFIX) begin
                  o = mark_second(data_byte, pos34, 1'b1, cur.body_seen,
                                  cur.scan_seen, bl34);
               end else if (pos34 + 34'd2 < bl34) begin
                  o = scan_first(data_byte, pos34, bl34);
               end else begin
                  o = '{phase: PH_MARK1, pending_ff: (data_byte == MRK_PREFIX),
                        fin: 1'b0, ok: 1'b0};
               end
            end
            default: begin
               nxt.phase = PH_DONE;
            end
         endcase
      end

      res = '{valid: 1'b0, ok: 1'b0, len: '0};
      if (apply) begin
         nxt.phase      = o.phase;
         nxt.pending_ff = o.pending_ff;
         res.valid      = o.fin;
         res.ok         = o.ok;
         res.len        = o.ok ? (cur.pos + 32'd1) : '0;
      end
   end

endmodule

// ----- sv/jpeg_extent_scanner.sv -----
// A byte waits in the input register and is decided when it is taken; its verdict,
// if any, is registered and shows on rsp_valid. Throughput: one byte per cycle
// while req_stall is low; the marker walk is a single registered state update.
// req_stall rises only while a verdict waits in the result register under rsp_stall.
// Reset (synchronous, active high) returns the parser to waiting for a first byte,
// drops any held byte or verdict, and sets buffer_length to 0 and min_size to 4.
module jpeg_extent_scanner
   import jes_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [7:0]              req_data_byte,
   input  logic                    req_first_byte,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_accepted,
   output logic [POS_W-1:0]        rsp_file_length,
   input  logic                    csr_write_en,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data
);

   logic [POS_W-1:0]      buffer_length_ff;
   logic [MIN_SIZE_W-1:0] min_size_ff;

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_first_ff;

   state_type  state_ff;
   state_type  state_in;
   result_type res;

   logic             out_valid_ff;
   logic             out_ok_ff;
   logic [POS_W-1:0] out_len_ff;

   logic proceed;
   logic take;

   // the held byte moves on unless a verdict is stuck in the output register
   assign proceed   = !out_valid_ff || !rsp_stall;
   assign take      = in_valid_ff && proceed;
   assign req_stall = in_valid_ff && !proceed;

   always_ff @(posedge clock) begin
      if (reset) begin
         buffer_length_ff <= BUFFER_LENGTH_RESET;
         min_size_ff      <= MIN_SIZE_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_BUFFER_LENGTH: buffer_length_ff <= csr_data;
            CSR_MIN_SIZE:      min_size_ff      <= csr_data[MIN_SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         in_valid_ff <= 1'b1;
      end else if (take) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff  <= req_data_byte;
         in_first_ff <= req_first_byte;
      end
   end

   jes_step u_step (
      .cur           (state_ff),
      .data_byte     (in_byte_ff),
      .first_byte    (in_first_ff),
      .buffer_length (buffer_length_ff),
      .min_size      (min_size_ff),
      .nxt           (state_in),
      .res           (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{phase: PH_IDLE, pos: '0, seg_end: '0, len_high: '0,
                       pending_ff: 1'b0, scan_seen: 1'b0, body_seen: 1'b0};
      end else if (take) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (take && res.valid) begin
         out_valid_ff <= 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take && res.valid) begin
         out_ok_ff  <= res.ok;
         out_len_ff <= res.len;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_accepted    = out_ok_ff;
   assign rsp_file_length = out_len_ff;

endmodule

// ----- sv/jes_checker.sv -----
module jes_checker
   import jes_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic             rsp_accepted,
   input logic [POS_W-1:0] rsp_file_length
);

   // a rejected buffer reports no length
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_accepted |-> rsp_file_length == '0)
      else $error("reject verdict carries a nonzero length");

   // hold a stalled verdict
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_accepted) &&
                                 $stable(rsp_file_length))
      else $error("stalled verdict changed or vanished");

   // no verdict survives reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("verdict present right after reset");

endmodule

bind jpeg_extent_scanner jes_checker u_jes_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_accepted    (rsp_accepted),
   .rsp_file_length (rsp_file_length)
);

// ----- tb/jes_verdict_checker.sv -----
module jes_verdict_checker
   import jes_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_first_byte,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic                   rsp_accepted,
   input  logic [POS_W-1:0]       rsp_file_length,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output int                     failures,
   output int                     pending
);

   typedef struct packed {
      logic             ok;
      logic [POS_W-1:0] len;
   } verdict_type;

   verdict_type verdict_q[$];
   verdict_type want;

   logic [POS_W-1:0]      buf_len;
   logic [MIN_SIZE_W-1:0] min_len;

   phase_type        ph;
   logic [POS_W-1:0] at_pos;
   logic [POS_W:0]   seg_end;
   logic [7:0]       len_hi;
   logic             ff_seen;
   logic             scan_flag;
   logic             body_flag;

   logic             got;
   verdict_type      got_v;

   task report_mismatch(input string what);
      $display("%0t: mismatch: %s", $time, what);
      failures++;
   endtask

   task conclude(input logic ok, input logic [63:0] n);
      ph = PH_DONE;
      got = 1'b1;
      got_v.ok = ok;
      got_v.len = ok ? n[POS_W-1:0] : '0;
   endtask

   task to_outer(input logic [63:0] at);
      if (at + 2 > buf_len) begin
         conclude(1'b0, 64'd0);
      end else begin
         ph = PH_MARK0;
         ff_seen = 1'b0;
      end
   endtask

   task to_scan(input logic [63:0] at);
      if (at + 2 < buf_len) begin
         ph = PH_SCAN;
         ff_seen = 1'b0;
      end else begin
         to_outer(at);
      end
   endtask

   task to_target(input logic sos, input logic [63:0] at);
      if (sos) begin
         to_scan(at);
      end else begin
         to_outer(at);
      end
   endtask

   task scan_lead(input logic [7:0] b, input logic [63:0] p);
      if (b == MRK_PREFIX) begin
         ff_seen = 1'b1;
         ph = PH_SCAN;
      end else begin
         to_scan(p + 1);
      end
   endtask

   // second byte of a pair whose first byte sits at p - 1
   task marker_tail(input logic [7:0] c, input logic [63:0] p, input logic ff);
      logic lone;
      lone = (c == MRK_TEM) || (c >= MRK_RST0 && c <= MRK_SOI);
      if (ff && c == MRK_EOI) begin
         conclude(body_flag, p + 1);
      end else if (ff && lone) begin
         to_outer(p + 1);
      end else if (p + 3 > buf_len) begin
         // truncated pair: accept only once a scan was seen
         conclude(scan_flag, p + 1);
      end else if (ff && c != MRK_STUFF && c != MRK_PREFIX) begin
         ph = (c == MRK_SOS) ? PH_LENH_SOS : PH_LENH;
      end else begin
         conclude(1'b0, 64'd0);
      end
   endtask

   task parse_byte(input logic [7:0] b, input logic first);
      logic [63:0] p;
      logic [63:0] seglen;
      logic [63:0] fin;
      logic        sos;
      got = 1'b0;
      if (first) begin
         seg_end = '0;
         len_hi = '0;
         ff_seen = 1'b0;
         scan_flag = 1'b0;
         body_flag = 1'b0;
         if (buf_len < min_len || buf_len < 2 || b != MRK_PREFIX) begin
            conclude(1'b0, 64'd0);
         end else begin
            ph = PH_SOI1;
         end
         at_pos = 32'd1;
      end else if (ph != PH_IDLE && ph != PH_DONE) begin
         p = {32'd0, at_pos};
         case (ph)
            PH_SOI1: begin
               if (b != MRK_SOI) conclude(1'b0, 64'd0);
               else to_outer(64'd2);
            end
            PH_MARK0: begin
               ff_seen = (b == MRK_PREFIX);
               ph = PH_MARK1;
            end
            PH_MARK1: marker_tail(b, p, ff_seen);
            PH_LENH, PH_LENH_SOS: begin
               len_hi = b;
               ph = (ph == PH_LENH) ? PH_LENL : PH_LENL_SOS;
            end
            PH_LENL, PH_LENL_SOS: begin
               sos = (ph == PH_LENL_SOS);
               seglen = {48'd0, len_hi, b};
               if (seglen < 2) begin
                  conclude(1'b0, 64'd0);
               end else begin
                  fin = p + seglen - 1;
                  body_flag = 1'b1;
                  if (sos) scan_flag = 1'b1;
                  if (fin + 2 > buf_len) begin
                     conclude(1'b0, 64'd0);
                  end else if (fin == p + 1) begin
                     to_target(sos, fin);
                  end else begin
                     seg_end = fin[POS_W:0];
                     ph = sos ? PH_SKIP_SOS : PH_SKIP;
                  end
               end
            end
            PH_SKIP, PH_SKIP_SOS: begin
               if (p + 1 >= seg_end) to_target(ph == PH_SKIP_SOS, {31'd0, seg_end});
            end
            PH_SCAN: begin
               if (!ff_seen) begin
                  scan_lead(b, p);
               end else if (b >= MRK_RST0 && b <= MRK_RST7) begin
                  to_scan(p + 1);
               end else if (b != MRK_STUFF && b != MRK_PREFIX) begin
                  marker_tail(b, p, 1'b1);
               end else if (p + 2 < buf_len) begin
                  ff_seen = 1'b0;
                  scan_lead(b, p);
               end else begin
                  // out of room: hand the pair to the outer walk
                  ph = PH_MARK1;
                  ff_seen = (b == MRK_PREFIX);
               end
            end
            default: ph = PH_DONE;
         endcase
         at_pos = at_pos + 32'd1;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         ph = PH_IDLE;
         at_pos = '0;
         seg_end = '0;
         len_hi = '0;
         ff_seen = 1'b0;
         scan_flag = 1'b0;
         body_flag = 1'b0;
         buf_len = BUFFER_LENGTH_RESET;
         min_len = MIN_SIZE_RESET;
         verdict_q.delete();
      end else begin
         if (req_valid && !req_stall) begin
            parse_byte(req_data_byte, req_first_byte);
            if (got) verdict_q.push_back(got_v);
         end
         if (rsp_valid && !rsp_stall) begin
            if (verdict_q.size() == 0) begin
               report_mismatch($sformatf("verdict with none expected: accepted %0b length %0d",
                                         rsp_accepted, rsp_file_length));
            end else begin
               want = verdict_q.pop_front();
               if (rsp_accepted !== want.ok) begin
                  report_mismatch($sformatf("accepted %0b, expected %0b",
                                            rsp_accepted, want.ok));
               end
               if (rsp_file_length !== want.len) begin
                  report_mismatch($sformatf("file_length %0d, expected %0d",
                                            rsp_file_length, want.len));
               end
            end
         end
         if (csr_write_en) begin
            case (csr_index)
               CSR_BUFFER_LENGTH: buf_len = csr_data;
               CSR_MIN_SIZE:      min_len = csr_data[MIN_SIZE_W-1:0];
               default: ;
            endcase
         end
      end
      pending = verdict_q.size();
   end

endmodule

// ----- tb/testbench.sv -----
module testbench;
   import jes_pkg::*;

   localparam logic [7:0] MRK_APP0    = 8'hE0;
   localparam logic [7:0] MRK_DHT     = 8'hC4;
   localparam int         ITEM_TARGET = 1550;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [7:0]             req_data_byte = '0;
   logic                   req_first_byte = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic                   rsp_accepted;
   logic [POS_W-1:0]       rsp_file_length;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   int         failures;
   int         pending;
   int         gap_pct = 0;
   int         stall_pct = 0;
   int         sent = 0;
   logic [7:0] stream_q[$];

   jpeg_extent_scanner DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data_byte(req_data_byte),
      .req_first_byte(req_first_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_accepted(rsp_accepted),
      .rsp_file_length(rsp_file_length),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   jes_verdict_checker verdicts (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data_byte(req_data_byte),
      .req_first_byte(req_first_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_accepted(rsp_accepted),
      .rsp_file_length(rsp_file_length),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .failures(failures),
      .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   initial begin
      #3_000_000;
      $display("jpeg_extent_scanner test failed");
      $finish;
   end

   // drop valid, drain every verdict, then let the last byte settle
   task settle();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      settle();
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task send_byte(input logic [7:0] value, input logic first);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_data_byte  <= value;
      req_first_byte <= first;
      // hold the payload until the transfer
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task run_buffer(input logic [31:0] blen, input int cut, input logic restarts);
      int i;
      write_reg(CSR_BUFFER_LENGTH, blen);
      for (i = 0; i < cut; i++) begin
         send_byte(stream_q[i], i == 0 || (restarts && $urandom_range(63) == 0));
         sent++;
      end
   endtask

   task add_pair(input logic [7:0] a, input logic [7:0] b);
      stream_q.push_back(a);
      stream_q.push_back(b);
   endtask

   task build_jpeg();
      int         k;
      int         j;
      int         kind;
      int         seglen;
      logic [7:0] m;
      stream_q.delete();
      add_pair(MRK_PREFIX, MRK_SOI);
      for (k = $urandom_range(4); k > 0; k--) begin
         kind = $urandom_range(5);
         case (kind)
            0: begin
               if ($urandom_range(1)) m = MRK_TEM;
               else m = 8'($urandom_range(MRK_RST0, MRK_SOI));
               add_pair(MRK_PREFIX, m);
            end
            5: add_pair(8'($urandom), 8'($urandom));
            default: begin
               if (kind >= 3) begin
                  m = MRK_SOS;
               end else begin
                  m = 8'($urandom_range(8'h02, 8'hFE));
                  if (m >= MRK_RST0 && m <= MRK_SOS) m = MRK_APP0;
               end
               case ($urandom_range(15))
                  0: seglen = $urandom_range(1);
                  1: seglen = $urandom_range(16'hFFFF);
                  default: seglen = $urandom_range(2, 10);
               endcase
               add_pair(MRK_PREFIX, m);
               add_pair(seglen[15:8], seglen[7:0]);
               for (j = 2; j < seglen && j < 14; j++) stream_q.push_back(8'($urandom));
               if (m == MRK_SOS) begin
                  // entropy-coded data with stuffing, restarts and fill
                  for (j = $urandom_range(12); j > 0; j--) begin
                     case ($urandom_range(9))
                        6: add_pair(MRK_PREFIX, MRK_STUFF);
                        7: add_pair(MRK_PREFIX, 8'($urandom_range(MRK_RST0, MRK_RST7)));
                        8: stream_q.push_back(MRK_PREFIX);
                        9: add_pair(MRK_PREFIX, 8'($urandom));
                        default: stream_q.push_back(8'($urandom_range(8'hFE)));
                     endcase
                  end
               end
            end
         endcase
      end
      if ($urandom_range(4) != 0) add_pair(MRK_PREFIX, MRK_EOI);
      if ($urandom_range(7) == 0) stream_q[$urandom_range(stream_q.size() - 1)] = 8'($urandom);
   endtask

   initial begin
      int          blk;
      int          base;
      int          msize;
      int          n;
      int          r;
      int          cut;
      logic [31:0] blen;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // smallest complete stream, then the byte-zero and truncation corners
      stream_q = '{MRK_PREFIX, MRK_SOI, MRK_PREFIX, MRK_APP0, 8'h00, 8'h02,
                   MRK_PREFIX, MRK_EOI};
      run_buffer(0, 1, 1'b0);
      run_buffer(1, 1, 1'b0);
      run_buffer(3, 1, 1'b0);
      run_buffer(8, 8, 1'b0);
      run_buffer(7, 8, 1'b0);
      run_buffer(32'hFFFF_FFFF, 8, 1'b0);
      stream_q = '{MRK_STUFF, MRK_SOI};
      run_buffer(8, 2, 1'b0);
      stream_q = '{MRK_PREFIX, MRK_STUFF};
      run_buffer(8, 2, 1'b0);
      stream_q = '{MRK_PREFIX, MRK_SOI, MRK_PREFIX, MRK_EOI};
      run_buffer(4, 4, 1'b0);
      stream_q = '{MRK_PREFIX, MRK_SOI, MRK_PREFIX, MRK_TEM, MRK_PREFIX, MRK_RST0,
                   MRK_PREFIX, MRK_DHT, 8'h00, 8'h03, 8'hAA, MRK_PREFIX, MRK_EOI};
      run_buffer(13, 13, 1'b0);
      stream_q = '{MRK_PREFIX, MRK_SOI, MRK_PREFIX, MRK_DHT, 8'h00, 8'h00};
      run_buffer(6, 6, 1'b0);
      stream_q = '{MRK_PREFIX, MRK_SOI, MRK_PREFIX, MRK_DHT, 8'hFF, 8'hFF};
      run_buffer(10, 6, 1'b0);
      stream_q = '{MRK_PREFIX, MRK_SOI, MRK_PREFIX, MRK_STUFF, 8'h00, 8'h04};
      run_buffer(6, 6, 1'b0);
      stream_q = '{MRK_PREFIX, MRK_SOI, MRK_PREFIX, MRK_SOS, 8'h00, 8'h02, 8'h12,
                   MRK_PREFIX, MRK_STUFF, MRK_PREFIX, MRK_RST7, 8'h34, MRK_PREFIX,
                   MRK_PREFIX, MRK_PREFIX, MRK_EOI};
      run_buffer(16, 16, 1'b0);
      run_buffer(11, 16, 1'b0);

      base = sent;
      for (blk = 0; blk < 8; blk++) begin
         case (blk % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 68; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 68; end
            default: begin gap_pct = 35; stall_pct = 35; end
         endcase
         if (blk == 2 || blk == 7) msize = 1024;
         else if (blk == 5) msize = $urandom_range(5, 48);
         else msize = 4;
         write_reg(CSR_MIN_SIZE, msize);
         while (sent < base + ITEM_TARGET * (blk + 1) / 8) begin
            if ($urandom_range(9) == 0) begin
               send_byte(8'($urandom), 1'b0);
               sent++;
            end
            build_jpeg();
            n = stream_q.size();
            r = $urandom_range(15);
            // keep most buffers above a large minimum so they get parsed
            if (msize == 1024 && r < 10) r = 15;
            case (r)
               9, 10:  blen = $urandom_range(n - 1);
               11, 12: blen = n + $urandom_range(1, 40);
               13:     blen = 32'hFFFF_FFFF;
               14:     blen = $urandom_range(3);
               15:     blen = $urandom_range(1023, 1100);
               default: blen = n;
            endcase
            cut = ($urandom_range(15) == 0) ? $urandom_range(1, n) : n;
            run_buffer(blen, cut, 1'b1);
         end
      end

      settle();
      if (failures == 0 && pending == 0) begin
         $display("jpeg_extent_scanner test passed");
      end else begin
         $display("jpeg_extent_scanner test failed");
      end
      $finish;
   end

endmodule
